/* design/sobb_pkg.sv */
// Package for the sphere/oriented-box overlap test.
// Payload structs, register indexes, reset values and lane helpers.
// No dependencies.
package sobb_pkg;

    localparam int CFG_W     = 48;
    localparam int LANE_W    = 16;
    localparam int RAD_W     = 15;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_BOX_CENTER  = 3'd0;
    localparam t_cfg_idx CFG_BOX_EXTENTS = 3'd1;
    localparam t_cfg_idx CFG_BOX_AXIS_0  = 3'd2;
    localparam t_cfg_idx CFG_BOX_AXIS_1  = 3'd3;
    localparam t_cfg_idx CFG_BOX_AXIS_2  = 3'd4;

    localparam logic [CFG_W-1:0] RST_BOX_CENTER  = 48'd0;
    localparam logic [CFG_W-1:0] RST_BOX_EXTENTS = 48'd0;
    localparam logic [CFG_W-1:0] RST_BOX_AXIS_0  = 48'h0000_0000_4000;
    localparam logic [CFG_W-1:0] RST_BOX_AXIS_1  = 48'h0000_4000_0000;
    localparam logic [CFG_W-1:0] RST_BOX_AXIS_2  = 48'h4000_0000_0000;

    typedef struct packed {
        logic signed [LANE_W-1:0] sphere_x;
        logic signed [LANE_W-1:0] sphere_y;
        logic signed [LANE_W-1:0] sphere_z;
        logic        [RAD_W-1:0]  sphere_radius;
    } t_sphere;

    typedef struct packed {
        logic                     hit;
        logic signed [LANE_W-1:0] closest_x;
        logic signed [LANE_W-1:0] closest_y;
        logic signed [LANE_W-1:0] closest_z;
    } t_result;

    typedef struct packed {
        t_cfg_idx         index;
        logic [CFG_W-1:0] value;
    } t_cfg_wr;

    // signed 16-bit lane k of a packed register, x in the low bits
    function automatic logic signed [LANE_W-1:0] lane_s(input logic [CFG_W-1:0] w,
                                                        input logic [1:0] k);
        return $signed(w[LANE_W*k +: LANE_W]);
    endfunction

    function automatic logic [LANE_W-1:0] lane_u(input logic [CFG_W-1:0] w,
                                                 input logic [1:0] k);
        return w[LANE_W*k +: LANE_W];
    endfunction

endpackage

/* design/sobb_stream_if.sv */
// Valid/ready channel with a typed payload.
// Used for the sphere, result and register-write channels; no dependencies.
interface sobb_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/sphere_obb_overlap_test.sv */
// Sphere versus oriented-box overlap test, eight-stage pipeline.
// Depends on sobb_pkg and sobb_stream_if.
//
//  channel    dir  payload                                       transaction
//  i_sphere   in   sphere_x/y/z (Q8.8), sphere_radius (unsigned Q7.8) valid & ready
//  o_result   out  hit, closest_x/y/z (Q8.8, saturated)          valid & ready
//  i_cfg      in   index (3b), value (48b); ready held high      valid & ready
//
// One sphere per cycle while o_result is not stalled; the result passes
// through the pipeline stages (offset, 9 products, projection/clamp,
// 9 products, accumulate/round, difference/saturate, squares, sum/compare).
// Synchronous active-low reset clears the stage valids and loads the box
// registers with their defaults. A stall on o_result freezes every stage;
// i_sphere.ready follows o_result.ready whenever the output holds a result.
module sphere_obb_overlap_test #(
    parameter int COORD_BITS     = 16,
    parameter int AXIS_FRAC_BITS = 14
) (
    input logic          i_clk,
    input logic          i_rst_n,
    sobb_stream_if.sink   i_sphere,
    sobb_stream_if.source o_result,
    sobb_stream_if.sink   i_cfg
);
    import sobb_pkg::*;

    localparam int F       = AXIS_FRAC_BITS;
    localparam int NSTG    = 8;
    localparam int D_W     = LANE_W + 1;
    localparam int PROD1_W = D_W + LANE_W;
    localparam int RND1_W  = PROD1_W + 3;
    localparam int PC_W    = LANE_W + 1;
    localparam int PROD2_W = PC_W + LANE_W;
    localparam int ACC_W   = ((LANE_W + F) > PROD2_W ? (LANE_W + F) : PROD2_W) + 2;
    localparam int RND2_W  = ACC_W + 1;
    localparam int PT_W    = RND2_W - F;
    localparam int DF_W    = PT_W + 1;
    localparam int SQ_W    = 2 * DF_W;
    localparam int DIST_W  = SQ_W + 2;
    localparam int R2_W    = 2 * RAD_W;
    localparam int SAT_W   = (PT_W > COORD_BITS ? PT_W : COORD_BITS) + 1;

    localparam logic signed [RND1_W-1:0] HALF1  = RND1_W'(64'd1 << (F - 1));
    localparam logic signed [RND2_W-1:0] HALF2  = RND2_W'(64'd1 << (F - 1));
    localparam logic signed [SAT_W-1:0]  SAT_HI = SAT_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [SAT_W-1:0]  SAT_LO = -SAT_HI - SAT_W'(1);

    // box registers
    logic [CFG_W-1:0] r_box_center;
    logic [CFG_W-1:0] r_box_ext;
    logic [CFG_W-1:0] r_axis [3];

    // pipeline control
    logic            w_en;
    logic [NSTG-1:0] r_vld;

    // stage registers
    logic signed [D_W-1:0]     r_s1_d  [3];
    logic signed [LANE_W-1:0]  r_s1_s  [3];
    logic        [RAD_W-1:0]   r_s1_r;
    logic signed [PROD1_W-1:0] r_s2_m  [3][3];
    logic signed [LANE_W-1:0]  r_s2_s  [3];
    logic        [RAD_W-1:0]   r_s2_r;
    logic signed [PC_W-1:0]    r_s3_p  [3];
    logic signed [LANE_W-1:0]  r_s3_s  [3];
    logic        [RAD_W-1:0]   r_s3_r;
    logic signed [PROD2_W-1:0] r_s4_q  [3][3];
    logic signed [LANE_W-1:0]  r_s4_s  [3];
    logic        [RAD_W-1:0]   r_s4_r;
    logic signed [PT_W-1:0]    r_s5_pt [3];
    logic signed [LANE_W-1:0]  r_s5_s  [3];
    logic        [R2_W-1:0]    r_s5_r2;
    logic signed [DF_W-1:0]    r_s6_df [3];
    logic        [LANE_W-1:0]  r_s6_cl [3];
    logic        [R2_W-1:0]    r_s6_r2;
    logic        [SQ_W-1:0]    r_s7_sq [3];
    logic        [LANE_W-1:0]  r_s7_cl [3];
    logic        [R2_W-1:0]    r_s7_r2;
    t_result                   r_out;

    // next values
    logic signed [D_W-1:0]     n_s1_d  [3];
    logic signed [PROD1_W-1:0] n_s2_m  [3][3];
    logic signed [PC_W-1:0]    n_s3_p  [3];
    logic signed [PROD2_W-1:0] n_s4_q  [3][3];
    logic signed [PT_W-1:0]    n_s5_pt [3];
    logic signed [DF_W-1:0]    n_s6_df [3];
    logic        [LANE_W-1:0]  n_s6_cl [3];
    logic        [SQ_W-1:0]    n_s7_sq [3];
    t_result                   n_out;
    logic signed [LANE_W-1:0]  w_in_s  [3];

    assign i_cfg.ready    = 1'b1;
    assign w_en           = o_result.ready || !r_vld[NSTG-1];
    assign i_sphere.ready = w_en;
    assign o_result.valid = r_vld[NSTG-1];
    assign o_result.data  = r_out;

    assign w_in_s[0] = i_sphere.data.sphere_x;
    assign w_in_s[1] = i_sphere.data.sphere_y;
    assign w_in_s[2] = i_sphere.data.sphere_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_center <= RST_BOX_CENTER;
            r_box_ext    <= RST_BOX_EXTENTS;
            r_axis[0]    <= RST_BOX_AXIS_0;
            r_axis[1]    <= RST_BOX_AXIS_1;
            r_axis[2]    <= RST_BOX_AXIS_2;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                CFG_BOX_CENTER:  r_box_center <= i_cfg.data.value;
                CFG_BOX_EXTENTS: r_box_ext    <= i_cfg.data.value;
                CFG_BOX_AXIS_0:  r_axis[0]    <= i_cfg.data.value;
                CFG_BOX_AXIS_1:  r_axis[1]    <= i_cfg.data.value;
                CFG_BOX_AXIS_2:  r_axis[2]    <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_sphere.valid};
        end
    end

    // stage 1: offset from box center
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s1_d[k] = D_W'(w_in_s[k]) - D_W'(lane_s(r_box_center, 2'(k)));
        end
    end

    // stage 2: offset times axis components
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_s2_m[i][k] = PROD1_W'(r_s1_d[k]) * PROD1_W'(lane_s(r_axis[i], 2'(k)));
            end
        end
    end

    // stage 3: projection, round, clamp to +/- extent
    always_comb begin
        logic signed [RND1_W-1:0] dot;
        logic signed [RND1_W-1:0] sh;
        logic signed [RND1_W-1:0] ext;
        for (int i = 0; i < 3; i++) begin
            dot = RND1_W'(r_s2_m[i][0]) + RND1_W'(r_s2_m[i][1])
                + RND1_W'(r_s2_m[i][2]) + HALF1;
            sh  = dot >>> F;
            ext = RND1_W'({1'b0, lane_u(r_box_ext, 2'(i))});
            if (sh > ext) begin
                n_s3_p[i] = ext[PC_W-1:0];
            end else if (sh < -ext) begin
                n_s3_p[i] = PC_W'(-ext);
            end else begin
                n_s3_p[i] = sh[PC_W-1:0];
            end
        end
    end

    // stage 4: clamped projection times axis components
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_s4_q[i][k] = PROD2_W'(r_s3_p[i]) * PROD2_W'(lane_s(r_axis[i], 2'(k)));
            end
        end
    end

    // stage 5: closest point, round
    always_comb begin
        logic signed [RND2_W-1:0] acc;
        logic signed [RND2_W-1:0] sh;
        for (int k = 0; k < 3; k++) begin
            acc = (RND2_W'(lane_s(r_box_center, 2'(k))) <<< F)
                + RND2_W'(r_s4_q[0][k]) + RND2_W'(r_s4_q[1][k])
                + RND2_W'(r_s4_q[2][k]) + HALF2;
            sh  = acc >>> F;
            n_s5_pt[k] = sh[PT_W-1:0];
        end
    end

    // stage 6: distance components, saturated outputs
    always_comb begin
        logic signed [SAT_W-1:0] pe;
        for (int k = 0; k < 3; k++) begin
            n_s6_df[k] = DF_W'(r_s5_pt[k]) - DF_W'(r_s5_s[k]);
            pe = SAT_W'(r_s5_pt[k]);
            if (pe > SAT_HI) begin
                n_s6_cl[k] = SAT_HI[LANE_W-1:0];
            end else if (pe < SAT_LO) begin
                n_s6_cl[k] = SAT_LO[LANE_W-1:0];
            end else begin
                n_s6_cl[k] = pe[LANE_W-1:0];
            end
        end
    end

    // stage 7: squares
    always_comb begin
        logic signed [SQ_W-1:0] sq;
        for (int k = 0; k < 3; k++) begin
            sq = SQ_W'(r_s6_df[k]) * SQ_W'(r_s6_df[k]);
            n_s7_sq[k] = sq;
        end
    end

    // stage 8: sum and compare
    always_comb begin
        logic [DIST_W-1:0] dist2;
        dist2 = DIST_W'(r_s7_sq[0]) + DIST_W'(r_s7_sq[1]) + DIST_W'(r_s7_sq[2]);
        n_out.hit       = (dist2 <= DIST_W'(r_s7_r2));
        n_out.closest_x = $signed(r_s7_cl[0]);
        n_out.closest_y = $signed(r_s7_cl[1]);
        n_out.closest_z = $signed(r_s7_cl[2]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_d  <= n_s1_d;
            r_s1_s  <= w_in_s;
            r_s1_r  <= i_sphere.data.sphere_radius;
            r_s2_m  <= n_s2_m;
            r_s2_s  <= r_s1_s;
            r_s2_r  <= r_s1_r;
            r_s3_p  <= n_s3_p;
            r_s3_s  <= r_s2_s;
            r_s3_r  <= r_s2_r;
            r_s4_q  <= n_s4_q;
            r_s4_s  <= r_s3_s;
            r_s4_r  <= r_s3_r;
            r_s5_pt <= n_s5_pt;
            r_s5_s  <= r_s4_s;
            r_s5_r2 <= R2_W'(r_s4_r) * R2_W'(r_s4_r);
            r_s6_df <= n_s6_df;
            r_s6_cl <= n_s6_cl;
            r_s6_r2 <= r_s5_r2;
            r_s7_sq <= n_s7_sq;
            r_s7_cl <= r_s6_cl;
            r_s7_r2 <= r_s6_r2;
            r_out   <= n_out;
        end
    end

    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sphere.valid && i_sphere.ready |=> r_vld[0])
        else $error("accepted sphere did not enter stage 1");

    a_stall_freezes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.ready |=> r_vld == $past(r_vld))
        else $error("pipeline occupancy changed during output stall");

    for (genvar g = 0; g < 3; g++) begin : g_clamp_chk
        a_clamp_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_vld[2] |-> (r_s3_p[g] <= $signed({1'b0, lane_u(r_box_ext, 2'(g))}))
                      && (r_s3_p[g] >= -$signed({1'b0, lane_u(r_box_ext, 2'(g))})))
            else $error("projection outside half extent");
    end

endmodule

/* tb/sobb_overlap_checker.sv */
// Scoreboard for the sphere/oriented-box overlap test: tracks box registers,
// predicts each contact result and compares it with the block's output.
// Depends on sobb_pkg.
module sobb_overlap_checker #(
    parameter int COORD_BITS     = 16,
    parameter int AXIS_FRAC_BITS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sphere_valid,
    input  logic              i_sphere_ready,
    input  sobb_pkg::t_sphere i_sphere_data,
    input  logic              i_result_valid,
    input  logic              i_result_ready,
    input  sobb_pkg::t_result i_result_data,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  sobb_pkg::t_cfg_wr i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);
    import sobb_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [CFG_W-1:0] box_center;
    logic [CFG_W-1:0] box_extents;
    logic [CFG_W-1:0] box_axis [3];
    t_result          predicted_contacts [$];
    t_result          want;
    int               mismatches = 0;

    function automatic longint round_frac(input longint v);
        return (v + (longint'(1) <<< (AXIS_FRAC_BITS - 1))) >>> AXIS_FRAC_BITS;
    endfunction

    function automatic t_result predict_contact(input t_sphere s);
        longint           pos [3];
        longint           off [3];
        longint           acc [3];
        longint           ctr, axc, dot, proj, ext, diff, dist_sq, rad, pt, sat_hi, sat_lo;
        logic [LANE_W-1:0] clamped [3];
        t_result          r;
        int               i, k;
        pos[0] = $signed(s.sphere_x);
        pos[1] = $signed(s.sphere_y);
        pos[2] = $signed(s.sphere_z);
        rad    = s.sphere_radius;
        sat_hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        sat_lo = -sat_hi - 1;
        for (k = 0; k < 3; k++) begin
            ctr    = $signed(box_center[LANE_W*k +: LANE_W]);
            off[k] = pos[k] - ctr;
            acc[k] = ctr <<< AXIS_FRAC_BITS;
        end
        for (i = 0; i < 3; i++) begin
            dot = 0;
            ext = box_extents[LANE_W*i +: LANE_W];
            for (k = 0; k < 3; k++) begin
                axc = $signed(box_axis[i][LANE_W*k +: LANE_W]);
                dot += off[k] * axc;
            end
            proj = round_frac(dot);
            if (proj > ext) proj = ext;
            if (proj < -ext) proj = -ext;
            for (k = 0; k < 3; k++) begin
                axc = $signed(box_axis[i][LANE_W*k +: LANE_W]);
                acc[k] += proj * axc;
            end
        end
        dist_sq = 0;
        for (k = 0; k < 3; k++) begin
            pt = round_frac(acc[k]);
            diff = pt - pos[k];
            dist_sq += diff * diff;
            if (pt > sat_hi) pt = sat_hi;
            if (pt < sat_lo) pt = sat_lo;
            clamped[k] = LANE_W'(pt);
        end
        r.hit       = (dist_sq <= rad * rad);
        r.closest_x = clamped[0];
        r.closest_y = clamped[1];
        r.closest_z = clamped[2];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            box_center  <= RST_BOX_CENTER;
            box_extents <= RST_BOX_EXTENTS;
            box_axis[0] <= RST_BOX_AXIS_0;
            box_axis[1] <= RST_BOX_AXIS_1;
            box_axis[2] <= RST_BOX_AXIS_2;
            predicted_contacts.delete();
            o_pending <= 0;
        end else begin
            if (i_result_valid && i_result_ready) begin
                if (predicted_contacts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result hit=%0d closest=(%0d,%0d,%0d)",
                                 $time, i_result_data.hit, i_result_data.closest_x,
                                 i_result_data.closest_y, i_result_data.closest_z);
                end else begin
                    want = predicted_contacts.pop_front();
                    if (i_result_data.hit !== want.hit ||
                        i_result_data.closest_x !== want.closest_x ||
                        i_result_data.closest_y !== want.closest_y ||
                        i_result_data.closest_z !== want.closest_z) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"%0t: result mismatch: expected hit=%0d ",
                                      "closest=(%0d,%0d,%0d), got hit=%0d closest=(%0d,%0d,%0d)"},
                                     $time, want.hit, want.closest_x, want.closest_y,
                                     want.closest_z, i_result_data.hit,
                                     i_result_data.closest_x, i_result_data.closest_y,
                                     i_result_data.closest_z);
                    end
                end
            end
            if (i_sphere_valid && i_sphere_ready)
                predicted_contacts.push_back(predict_contact(i_sphere_data));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.index)
                    CFG_BOX_CENTER:  box_center  <= i_cfg_data.value;
                    CFG_BOX_EXTENTS: box_extents <= i_cfg_data.value;
                    CFG_BOX_AXIS_0:  box_axis[0] <= i_cfg_data.value;
                    CFG_BOX_AXIS_1:  box_axis[1] <= i_cfg_data.value;
                    CFG_BOX_AXIS_2:  box_axis[2] <= i_cfg_data.value;
                    default: ;
                endcase
            end
            o_pending <= predicted_contacts.size();
        end
        o_fail_count <= mismatches;
    end

endmodule

/* tb/tb_sphere_obb_overlap_test.sv */
// Top of the sphere/oriented-box overlap testbench: clock, reset, box setup,
// sphere stimulus and output back-pressure. Depends on sobb_pkg,
// sobb_stream_if, sphere_obb_overlap_test and sobb_overlap_checker.
module tb_sphere_obb_overlap_test;
    import sobb_pkg::*;

    localparam int HOLD_CYCLES = 64;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   sender_idle   = 1'b0;
    bit   recv_idle     = 1'b0;
    bit   hold_request  = 1'b0;
    logic [CFG_W-1:0] cur_center = RST_BOX_CENTER;

    sobb_stream_if #(.T(t_sphere)) sphere_ch ();
    sobb_stream_if #(.T(t_result)) result_ch ();
    sobb_stream_if #(.T(t_cfg_wr)) cfg_ch ();

    sphere_obb_overlap_test u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sphere (sphere_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    sobb_overlap_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sphere_valid (sphere_ch.valid),
        .i_sphere_ready (sphere_ch.ready),
        .i_sphere_data  (sphere_ch.data),
        .i_result_valid (result_ch.valid),
        .i_result_ready (result_ch.ready),
        .i_result_data  (result_ch.data),
        .i_cfg_valid    (cfg_ch.valid),
        .i_cfg_ready    (cfg_ch.ready),
        .i_cfg_data     (cfg_ch.data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic send_sphere(input t_sphere s);
        if (sender_idle && $urandom_range(0, 4) == 0) begin
            sphere_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        sphere_ch.valid <= 1'b1;
        sphere_ch.data  <= s;
        do @(posedge i_clk); while (!sphere_ch.ready);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        if (idx == CFG_BOX_CENTER) cur_center = val;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= t_cfg_wr'{index: idx, value: val};
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic write_box(input logic [CFG_W-1:0] ctr, input logic [CFG_W-1:0] ext,
                             input logic [CFG_W-1:0] ax0, input logic [CFG_W-1:0] ax1,
                             input logic [CFG_W-1:0] ax2);
        write_reg(CFG_BOX_CENTER, ctr);
        write_reg(CFG_BOX_EXTENTS, ext);
        write_reg(CFG_BOX_AXIS_0, ax0);
        write_reg(CFG_BOX_AXIS_1, ax1);
        write_reg(CFG_BOX_AXIS_2, ax2);
        cfg_ch.valid <= 1'b0;
    endtask

    // wait until every outstanding sphere has produced its result
    task automatic drain();
        sphere_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic load_random_box();
        logic [LANE_W-1:0] cs, sn;
        logic [CFG_W-1:0]  ctr, ext, ax0, ax1, ax2;
        int                k;
        case ($urandom_range(0, 3))
            0: begin cs = 16'h4000; sn = 16'h0000; end
            1: begin cs = 16'h2D41; sn = 16'h2D41; end
            2: begin cs = 16'h376D; sn = 16'h2000; end
            default: begin cs = 16'h2000; sn = 16'h376D; end
        endcase
        if ($urandom_range(0, 1) == 1) sn = -sn;
        for (k = 0; k < 3; k++) begin
            ctr[LANE_W*k +: LANE_W] = LANE_W'($urandom_range(0, 4096) - 2048);
            ext[LANE_W*k +: LANE_W] = ($urandom_range(0, 5) == 0) ? '0 :
                                      LANE_W'($urandom_range(1, 2048));
        end
        case ($urandom_range(0, 3))
            0: begin
                ax0 = {16'h0000, sn, cs};
                ax1 = {16'h0000, cs, -sn};
                ax2 = RST_BOX_AXIS_2;
            end
            1: begin
                ax0 = RST_BOX_AXIS_0;
                ax1 = {sn, cs, 16'h0000};
                ax2 = {cs, -sn, 16'h0000};
            end
            2: begin
                ax0 = {-sn, 16'h0000, cs};
                ax1 = RST_BOX_AXIS_1;
                ax2 = {cs, 16'h0000, sn};
            end
            default: begin
                ctr = CFG_W'({$urandom, $urandom});
                ext = CFG_W'({$urandom, $urandom});
                ax0 = CFG_W'({$urandom, $urandom});
                ax1 = CFG_W'({$urandom, $urandom});
                ax2 = CFG_W'({$urandom, $urandom});
            end
        endcase
        write_box(ctr, ext, ax0, ax1, ax2);
    endtask

    initial begin : result_ready_driver
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
                result_ch.ready <= 1'b1;
            end else if (recv_idle && $urandom_range(0, 5) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        t_sphere sph;
        int      phase, n, burst;
        i_rst_n         <= 1'b0;
        sphere_ch.valid <= 1'b0;
        sphere_ch.data  <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.data     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset box: zero extents, closest point pinned to the origin
        sender_idle = 1'b1;
        recv_idle   = 1'b1;
        send_sphere(t_sphere'{16'sh0000, 16'sh0000, 16'sh0000, 15'h0000});
        send_sphere(t_sphere'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 15'h7FFF});
        send_sphere(t_sphere'{16'sh8000, 16'sh8000, 16'sh8000, 15'h0000});
        send_sphere(t_sphere'{16'sh5555, 16'shAAAA, 16'sh5555, 15'h2AAA});
        send_sphere(t_sphere'{16'shAAAA, 16'sh5555, 16'shAAAA, 15'h5555});
        drain();

        // axis-aligned box: inside, exact touch, just missing, far corner
        write_box(48'h0200_FF00_0100, 48'h0300_0200_0100,
                  RST_BOX_AXIS_0, RST_BOX_AXIS_1, RST_BOX_AXIS_2);
        send_sphere(t_sphere'{16'sh0100, 16'shFF00, 16'sh0200, 15'h0000});
        send_sphere(t_sphere'{16'sh0400, 16'shFF00, 16'sh0200, 15'h0200});
        send_sphere(t_sphere'{16'sh0400, 16'shFF00, 16'sh0200, 15'h01FF});
        send_sphere(t_sphere'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 15'h1000});
        drain();

        // extreme box: max extents, oversized and zero axes, saturation
        write_box(48'h8000_8000_8000, 48'hFFFF_FFFF_FFFF,
                  48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h0000_0000_0000);
        send_sphere(t_sphere'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 15'h7FFF});
        send_sphere(t_sphere'{16'sh8000, 16'sh8000, 16'sh8000, 15'h0000});
        send_sphere(t_sphere'{16'sh0000, 16'sh0000, 16'sh0000, 15'h7FFF});
        send_sphere(t_sphere'{16'sh7FFF, 16'sh8000, 16'sh0000, 15'h1234});
        send_sphere(t_sphere'{16'sh8000, 16'sh7FFF, 16'sh7FFF, 15'h0000});
        drain();

        // rotated box with zero extents on two axes; unmapped indexes ignored
        write_box(48'h7FFF_7FFF_7FFF, 48'h0000_FFFF_0000,
                  48'h0000_2D41_2D41, 48'h0000_2D41_D2BF, RST_BOX_AXIS_2);
        for (n = CFG_BOX_AXIS_2 + 1; n < 2 ** CFG_IDX_W; n++)
            write_reg(t_cfg_idx'(n), CFG_W'({$urandom, $urandom}));
        cfg_ch.valid <= 1'b0;
        send_sphere(t_sphere'{16'sh0000, 16'sh0000, 16'sh0000, 15'h4000});
        send_sphere(t_sphere'{16'sh8000, 16'sh8000, 16'sh8000, 15'h7FFF});
        send_sphere(t_sphere'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 15'h0000});
        send_sphere(t_sphere'{16'sh1234, 16'sh7000, 16'sh7FFF, 15'h0100});
        drain();

        for (phase = 0; phase < 9; phase++) begin
            load_random_box();
            sender_idle = (phase % 3 != 1) && (phase != 2) && (phase != 8);
            recv_idle   = (phase % 4 != 3) && (phase != 8);
            if (phase == 2) hold_request = 1'b1;
            burst = (phase == 8) ? 140 : 120;
            for (n = 0; n < burst; n++) begin
                if ($urandom_range(0, 9) < 3) begin
                    sph.sphere_x      = LANE_W'($urandom);
                    sph.sphere_y      = LANE_W'($urandom);
                    sph.sphere_z      = LANE_W'($urandom);
                    sph.sphere_radius = RAD_W'($urandom);
                end else begin
                    sph.sphere_x = cur_center[15:0] + LANE_W'($urandom_range(0, 6144) - 3072);
                    sph.sphere_y = cur_center[31:16] + LANE_W'($urandom_range(0, 6144) - 3072);
                    sph.sphere_z = cur_center[47:32] + LANE_W'($urandom_range(0, 6144) - 3072);
                    sph.sphere_radius = RAD_W'($urandom_range(0, 2048));
                end
                send_sphere(sph);
            end
            drain();
        end

        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
